// ----- src/rs_enc_pkg.sv -----
// Shared types, constants and GF(2^8) helpers for the RS(255,223) encoder.
package rs_enc_pkg;

  localparam int SymW       = 8;
  localparam int NPar       = 32;
  localparam int ParCntW    = $clog2(NPar + 1);
  localparam int QueueDepth = 2;
  localparam int ExpW       = 8;

  localparam logic [SymW-1:0] FieldPolyReset = 8'h87;
  // highest generator exponent; the coefficient sweep ends here
  localparam logic [ExpW-1:0] MaxExp = 8'd251;

  // generator coefficients as powers of alpha, tap 0 up to tap 31
  localparam logic [ExpW-1:0] TapExp [NPar] = '{
    8'd0,   8'd249, 8'd59,  8'd66,  8'd4,   8'd43,  8'd126, 8'd251,
    8'd97,  8'd30,  8'd3,   8'd213, 8'd50,  8'd66,  8'd170, 8'd5,
    8'd24,  8'd5,   8'd170, 8'd66,  8'd50,  8'd213, 8'd3,   8'd30,
    8'd97,  8'd251, 8'd126, 8'd43,  8'd4,   8'd66,  8'd59,  8'd249
  };

  typedef logic [SymW-1:0] sym_t;
  typedef logic [NPar-1:0][SymW-1:0] sym_vec_t;

  // word held in the queue between front and back
  typedef struct packed {
    sym_t sym;
    logic eob;
  } q_item_t;

  // field state seen by the back end
  typedef struct packed {
    logic busy;
    sym_t poly;
  } field_stat_t;

  // back end status, for checks at the top
  typedef struct packed {
    logic par_busy;
    logic pop;
  } back_stat_t;

  function automatic sym_t gf_times_x(sym_t a, sym_t poly);
    sym_t s;
    s = {a[SymW-2:0], 1'b0};
    if (a[SymW-1]) begin
      s = s ^ poly;
    end
    return s;
  endfunction

  function automatic sym_t gf_mul(sym_t a, sym_t b, sym_t poly);
    sym_t acc;
    sym_t m;
    acc = '0;
    m   = a;
    for (int i = 0; i < SymW; i++) begin
      if (b[i]) begin
        acc = acc ^ m;
      end
      m = gf_times_x(m, poly);
    end
    return acc;
  endfunction

endpackage

// ----- src/rs_enc_if.sv -----
// Stream and configuration channel interfaces of the RS encoder.
interface rs_enc_in_if import rs_enc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t data_symbol;
  logic end_of_block;

  modport source (output valid, data_symbol, end_of_block, input ready);
  modport sink (input valid, data_symbol, end_of_block, output ready);
endinterface

interface rs_enc_out_if import rs_enc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t code_symbol;
  logic is_parity;
  logic last_of_run;

  modport source (output valid, code_symbol, is_parity, last_of_run, input ready);
  modport sink (input valid, code_symbol, is_parity, last_of_run, output ready);
endinterface

interface rs_enc_cfg_if import rs_enc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t field_poly;

  modport source (output valid, field_poly, input ready);
  modport sink (input valid, field_poly, output ready);
endinterface

// ----- src/rs_255_223_encoder_unit.sv -----
// RS(255,223) systematic encoder, echo then 32 parity bytes: one data byte per cycle
// while not stalled, bound by the single LFSR update. An accepted byte is written to the
// queue, then on pop steps the LFSR and is registered as its echo word; an end-of-block
// byte is followed by its 32 parity words; no byte leaves the queue while they unload.
// Reset (async, active low) clears the remainder, queue and output; after reset and after
// every field_poly write the tap coefficients are rebuilt by a sweep, no input taken.
module rs_255_223_encoder_unit import rs_enc_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rs_enc_in_if.sink    in_i,
  rs_enc_out_if.source out_o,
  rs_enc_cfg_if.sink   cfg_i
);

  field_stat_t field_stat;
  sym_vec_t    coef;
  logic        q_valid;
  q_item_t     q_item;
  logic        q_pop;
  back_stat_t  back_stat;

  rs_enc_coef_gen u_coef_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .field_stat_o (field_stat),
    .coef_o       (coef)
  );

  rs_enc_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .hold_i    (field_stat.busy),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  rs_enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .field_stat_i (field_stat),
    .coef_i       (coef),
    .out_o        (out_o),
    .back_stat_o  (back_stat)
  );

  // no word enters while coefficients are being rebuilt
  a_no_accept_during_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_stat.busy |-> !(in_i.valid && in_i.ready))
    else $error("input accepted during coefficient build");

  // parity unload must finish before the next word leaves the queue
  a_no_pop_during_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.par_busy |-> !back_stat.pop)
    else $error("queue popped while parity unloads");

  // a field write always starts a new build
  a_cfg_starts_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready) |=> field_stat.busy)
    else $error("field write did not start coefficient build");

endmodule

// ----- src/rs_enc_coef_gen.sv -----
// Field polynomial register and sequential build of the generator coefficients.
module rs_enc_coef_gen import rs_enc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rs_enc_cfg_if.sink  cfg_i,
  output field_stat_t field_stat_o,
  output sym_vec_t    coef_o
);

  sym_t            poly_q, poly_d;
  logic            busy_q, busy_d;
  logic [ExpW-1:0] step_q, step_d;
  sym_t            pow_q, pow_d;
  sym_vec_t        coef_q;

  logic cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid & cfg_i.ready;

  always_comb begin
    poly_d = poly_q;
    busy_d = busy_q;
    step_d = step_q;
    pow_d  = pow_q;
    if (cfg_wr) begin
      // a new field restarts the sweep from alpha^0
      poly_d = cfg_i.field_poly;
      busy_d = 1'b1;
      step_d = '0;
      pow_d  = sym_t'(1);
    end else if (busy_q) begin
      pow_d  = gf_times_x(pow_q, poly_q);
      step_d = step_q + 1'b1;
      if (step_q == MaxExp) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= FieldPolyReset;
      busy_q <= 1'b1;
      step_q <= '0;
      pow_q  <= sym_t'(1);
    end else begin
      poly_q <= poly_d;
      busy_q <= busy_d;
      step_q <= step_d;
      pow_q  <= pow_d;
    end
  end

  // each tap picks up alpha^step when the sweep passes its exponent
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NPar; i++) begin
      if (busy_q && !cfg_wr && (TapExp[i] == step_q)) begin
        coef_q[i] <= pow_q;
      end
    end
  end

  assign field_stat_o.busy = busy_q;
  assign field_stat_o.poly = poly_q;
  assign coef_o            = coef_q;

endmodule

// ----- src/rs_enc_front.sv -----
// Input acceptance and short word queue ahead of the LFSR back end.
module rs_enc_front import rs_enc_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rs_enc_in_if.sink  in_i,
  input  logic       hold_i,
  output logic       q_valid_o,
  output q_item_t    q_item_o,
  input  logic       q_pop_i
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  q_item_t         mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic push;
  logic pop;

  assign in_i.ready = !hold_i && (cnt_q != CntW'(QDepth));
  assign push       = in_i.valid & in_i.ready;
  assign pop        = q_pop_i & q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{sym: in_i.data_symbol, eob: in_i.end_of_block};
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

endmodule

// ----- src/rs_enc_back.sv -----
// LFSR remainder update, parity unload and output register.
module rs_enc_back import rs_enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  q_item_t       q_item_i,
  output logic          q_pop_o,
  input  field_stat_t   field_stat_i,
  input  sym_vec_t      coef_i,
  rs_enc_out_if.source  out_o,
  output back_stat_t    back_stat_o
);

  sym_vec_t           rem_q, rem_d;
  logic [ParCntW-1:0] par_left_q, par_left_d;
  logic               out_valid_q, out_valid_d;
  sym_t               out_sym_q, out_sym_d;
  logic               out_par_q, out_par_d;
  logic               out_last_q, out_last_d;

  logic     out_free;
  logic     pop;
  logic     par_busy;
  sym_t     fb;
  sym_vec_t rem_upd;

  assign out_free = !out_valid_q || out_o.ready;
  assign par_busy = (par_left_q != '0);
  assign pop      = q_valid_i && !par_busy && out_free && !field_stat_i.busy;

  assign fb = rem_q[NPar-1] ^ q_item_i.sym;

  always_comb begin
    rem_upd[0] = gf_mul(fb, coef_i[0], field_stat_i.poly);
    for (int i = 1; i < NPar; i++) begin
      rem_upd[i] = gf_mul(fb, coef_i[i], field_stat_i.poly) ^ rem_q[i-1];
    end
  end

  always_comb begin
    rem_d       = rem_q;
    par_left_d  = par_left_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_par_d   = out_par_q;
    out_last_d  = out_last_q;
    if (pop) begin
      rem_d       = rem_upd;
      par_left_d  = q_item_i.eob ? ParCntW'(NPar) : '0;
      out_valid_d = 1'b1;
      out_sym_d   = q_item_i.sym;
      out_par_d   = 1'b0;
      out_last_d  = !q_item_i.eob;
    end else if (par_busy && out_free) begin
      // unload top symbol first; zeros shifted in leave the remainder cleared
      rem_d       = {rem_q[NPar-2:0], sym_t'(0)};
      par_left_d  = par_left_q - 1'b1;
      out_valid_d = 1'b1;
      out_sym_d   = rem_q[NPar-1];
      out_par_d   = 1'b1;
      out_last_d  = (par_left_q == ParCntW'(1));
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      par_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      par_left_q  <= par_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sym_q  <= out_sym_d;
    out_par_q  <= out_par_d;
    out_last_q <= out_last_d;
  end

  assign q_pop_o           = pop;
  assign out_o.valid       = out_valid_q;
  assign out_o.code_symbol = out_sym_q;
  assign out_o.is_parity   = out_par_q;
  assign out_o.last_of_run = out_last_q;

  assign back_stat_o.par_busy = par_busy;
  assign back_stat_o.pop      = pop;

endmodule
